// File: rtl/scfp_pkg.sv
package scfp_pkg;

  localparam logic [7:0] StartLocal   = 8'hBB;
  localparam logic [7:0] StartRelay   = 8'hAA;
  localparam logic [7:0] MarkLocal    = 8'hF4;
  localparam logic [7:0] MarkRelay    = 8'h31;
  localparam logic [7:0] OrderTakeoff = 8'h00;
  localparam logic [7:0] OrderGoto    = 8'h01;
  localparam logic [7:0] OrderLand    = 8'h02;

  // payload byte positions of the captured fields
  localparam logic [7:0] PosDestId    = 8'd1;
  localparam logic [7:0] PosOrder     = 8'd2;
  localparam logic [7:0] PosWordFirst = 8'd3;
  localparam logic [7:0] PosWordLast  = 8'd14;

  localparam logic [7:0] OwnIdReset   = 8'd1;

  typedef enum logic [2:0] {
    VERDICT_NONE    = 3'd0,
    VERDICT_ABORT   = 3'd1,
    VERDICT_BADSUM  = 3'd2,
    VERDICT_FORWARD = 3'd3,
    VERDICT_TAKEOFF = 3'd4,
    VERDICT_GOTO    = 3'd5,
    VERDICT_LAND    = 3'd6,
    VERDICT_UNKNOWN = 3'd7
  } verdict_e;

  localparam int unsigned NumWords = 3;

endpackage

// File: rtl/serial_command_frame_parser.sv
// Command frame parser for a byte stream: start byte (0xBB local, 0xAA relay), length
// byte, max(length,1) payload bytes with a function marker first, then an 8-bit sum
// byte. Every accepted byte gives exactly one result transaction in the next cycle,
// carrying the byte itself, frame membership, a verdict on the closing byte and the
// captured length, order byte and three little-endian words. One byte is taken per
// cycle; the output register is the only buffer, so input stalls only while a result
// sits in it and the output side stalls. own_id is to be written only while idle.
module serial_command_frame_parser
  import scfp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        own_id_we_i,
  input  logic [7:0]  own_id_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  echo_byte_o,
  output logic        in_frame_o,
  output logic        frame_end_o,
  output logic [2:0]  verdict_o,
  output logic [7:0]  payload_length_o,
  output logic [7:0]  order_code_o,
  output logic [31:0] word_first_o,
  output logic [31:0] word_second_o,
  output logic [31:0] word_third_o
);

  typedef enum logic [1:0] {
    PH_WAIT    = 2'd0,
    PH_LEN     = 2'd1,
    PH_PAYLOAD = 2'd2,
    PH_SUM     = 2'd3
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [7:0]  own_id_q;
  logic [7:0]  count_q, count_d;
  logic [7:0]  len_q, len_d;
  logic        relay_q, relay_d;
  logic [7:0]  sum_q, sum_d;
  logic [7:0]  dest_q, dest_d;
  logic [7:0]  order_q, order_d;
  logic [31:0] words_q [NumWords];
  logic [31:0] words_d [NumWords];

  logic        accept;
  logic        out_valid_q;
  logic [7:0]  echo_q;
  logic        in_frame_q, in_frame_d;
  logic        end_q, end_d;
  verdict_e    verdict_q, verdict_d;

  logic [7:0]  count_inc;
  logic [3:0]  off;
  logic        mark_ok;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  assign count_inc = count_q + 8'd1;
  assign off       = 4'(count_q - PosWordFirst);
  assign mark_ok   = relay_q ? (rx_byte_i == MarkRelay) : (rx_byte_i == MarkLocal);

  always_comb begin
    phase_d    = phase_q;
    count_d    = count_q;
    len_d      = len_q;
    relay_d    = relay_q;
    sum_d      = sum_q;
    dest_d     = dest_q;
    order_d    = order_q;
    words_d    = words_q;
    in_frame_d = 1'b0;
    end_d      = 1'b0;
    verdict_d  = VERDICT_NONE;
    case (phase_q)
      PH_WAIT: begin
        if (rx_byte_i == StartLocal || rx_byte_i == StartRelay) begin
          in_frame_d = 1'b1;
          relay_d    = (rx_byte_i == StartRelay);
          sum_d      = rx_byte_i;
          count_d    = '0;
          dest_d     = '0;
          order_d    = '0;
          for (int i = 0; i < NumWords; i++) words_d[i] = '0;
          phase_d    = PH_LEN;
        end
      end
      PH_LEN: begin
        in_frame_d = 1'b1;
        len_d      = rx_byte_i;
        sum_d      = sum_q + rx_byte_i;
        count_d    = '0;
        phase_d    = PH_PAYLOAD;
      end
      PH_PAYLOAD: begin
        in_frame_d = 1'b1;
        if (count_q == 8'd0 && !mark_ok) begin
          // wrong function marker, byte dropped
          end_d     = 1'b1;
          verdict_d = VERDICT_ABORT;
          phase_d   = PH_WAIT;
          count_d   = '0;
        end else begin
          if (count_q == PosDestId) begin
            dest_d = rx_byte_i;
          end else if (count_q == PosOrder) begin
            order_d = rx_byte_i;
          end else if (count_q >= PosWordFirst && count_q <= PosWordLast) begin
            words_d[off[3:2]][{off[1:0], 3'b000} +: 8] = rx_byte_i;
          end
          sum_d   = sum_q + rx_byte_i;
          count_d = count_inc;
          if (count_inc >= len_q) begin
            phase_d = PH_SUM;
            count_d = '0;
          end
        end
      end
      PH_SUM: begin
        in_frame_d = 1'b1;
        end_d      = 1'b1;
        if (sum_q != rx_byte_i) begin
          verdict_d = VERDICT_BADSUM;
        end else if (dest_q != own_id_q || relay_q) begin
          verdict_d = VERDICT_FORWARD;
        end else if (order_q == OrderTakeoff) begin
          verdict_d = VERDICT_TAKEOFF;
        end else if (order_q == OrderGoto) begin
          verdict_d = VERDICT_GOTO;
        end else if (order_q == OrderLand) begin
          verdict_d = VERDICT_LAND;
        end else begin
          verdict_d = VERDICT_UNKNOWN;
        end
        phase_d = PH_WAIT;
        count_d = '0;
      end
      default: phase_d = PH_WAIT;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_WAIT;
      own_id_q    <= OwnIdReset;
      count_q     <= '0;
      len_q       <= '0;
      relay_q     <= 1'b0;
      sum_q       <= '0;
      dest_q      <= '0;
      order_q     <= '0;
      for (int i = 0; i < NumWords; i++) words_q[i] <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (own_id_we_i) begin
        own_id_q <= own_id_i;
      end
      if (accept) begin
        phase_q     <= phase_d;
        count_q     <= count_d;
        len_q       <= len_d;
        relay_q     <= relay_d;
        sum_q       <= sum_d;
        dest_q      <= dest_d;
        order_q     <= order_d;
        words_q     <= words_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result register, payload only
  always_ff @(posedge clk_i) begin
    if (accept) begin
      echo_q     <= rx_byte_i;
      in_frame_q <= in_frame_d;
      end_q      <= end_d;
      verdict_q  <= verdict_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign echo_byte_o      = echo_q;
  assign in_frame_o       = in_frame_q;
  assign frame_end_o      = end_q;
  assign verdict_o        = verdict_q;
  // captures are held in state and only change on an accepted byte
  assign payload_length_o = len_q;
  assign order_code_o     = order_q;
  assign word_first_o     = words_q[0];
  assign word_second_o    = words_q[1];
  assign word_third_o     = words_q[2];

  a_verdict_only_at_end : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && verdict_q != VERDICT_NONE |-> end_q && in_frame_q)
    else $error("verdict without frame end");

  a_end_has_verdict : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && end_q |-> verdict_q != VERDICT_NONE)
    else $error("frame end without verdict");

  a_end_returns_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && end_d |=> phase_q == PH_WAIT && count_q == 8'd0)
    else $error("parser not idle after frame end");

  a_count_zero_outside_payload : assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q != PH_PAYLOAD |-> count_q == 8'd0)
    else $error("payload count nonzero outside payload");

  a_full_output_blocks_input : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_stall_i |-> !accept)
    else $error("byte accepted while result register held");

endmodule

// File: tb/tb_serial_command_frame_parser.sv
`timescale 1ns / 100ps

module tb_serial_command_frame_parser;
  import scfp_pkg::*;

  localparam int CycleLimit = 400000;

  typedef enum logic [1:0] {
    WAIT_START,
    GET_LENGTH,
    GET_PAYLOAD,
    GET_SUM
  } parse_phase_e;

  typedef struct packed {
    logic [7:0]  echo;
    logic        in_frame;
    logic        frame_end;
    verdict_e    verdict;
    logic [7:0]  len;
    logic [7:0]  order;
    logic [31:0] w0;
    logic [31:0] w1;
    logic [31:0] w2;
  } frame_result_t;

  class frame_scoreboard;
    logic [7:0]    own_id;
    parse_phase_e  parse_phase;
    logic [7:0]    pay_cnt;
    logic [7:0]    frame_len;
    logic          relay;
    logic [7:0]    running_sum;
    logic [7:0]    dest_id;
    logic [7:0]    order_b;
    logic [31:0]   words [NumWords];
    frame_result_t pending [$];
    int            failures;
    int            results_seen;
    int            verdict_count [8];

    function new();
      own_id      = OwnIdReset;
      parse_phase = WAIT_START;
      pay_cnt     = '0;
      frame_len   = '0;
      relay       = 1'b0;
      running_sum = '0;
      dest_id     = '0;
      order_b     = '0;
      foreach (words[i]) words[i] = '0;
      foreach (verdict_count[i]) verdict_count[i] = 0;
      failures     = 0;
      results_seen = 0;
    endfunction

    function void capture_payload(logic [7:0] b);
      logic [7:0] off;
      if (pay_cnt == PosDestId) begin
        dest_id = b;
      end else if (pay_cnt == PosOrder) begin
        order_b = b;
      end else if (pay_cnt >= PosWordFirst && pay_cnt <= PosWordLast) begin
        off = pay_cnt - PosWordFirst;
        words[off[3:2]][off[1:0]*8 +: 8] = b;
      end
    endfunction

    // advance the parser by one accepted byte and queue the expected transaction
    function void note_byte(logic [7:0] b);
      frame_result_t r;
      r = '0;
      r.echo = b;
      r.verdict = VERDICT_NONE;
      case (parse_phase)
        WAIT_START: begin
          if (b == StartLocal || b == StartRelay) begin
            r.in_frame  = 1'b1;
            relay       = (b == StartRelay);
            running_sum = b;
            pay_cnt     = '0;
            dest_id     = '0;
            order_b     = '0;
            foreach (words[i]) words[i] = '0;
            parse_phase = GET_LENGTH;
          end
        end
        GET_LENGTH: begin
          r.in_frame  = 1'b1;
          frame_len   = b;
          running_sum = running_sum + b;
          pay_cnt     = '0;
          parse_phase = GET_PAYLOAD;
        end
        GET_PAYLOAD: begin
          r.in_frame = 1'b1;
          if (pay_cnt == 0 && b != (relay ? MarkRelay : MarkLocal)) begin
            r.frame_end = 1'b1;
            r.verdict   = VERDICT_ABORT;
            parse_phase = WAIT_START;
            pay_cnt     = '0;
          end else begin
            capture_payload(b);
            running_sum = running_sum + b;
            pay_cnt     = pay_cnt + 8'd1;
            // a zero length still takes the marker byte
            if (pay_cnt >= frame_len) begin
              parse_phase = GET_SUM;
              pay_cnt     = '0;
            end
          end
        end
        default: begin
          r.in_frame  = 1'b1;
          r.frame_end = 1'b1;
          if (running_sum != b) r.verdict = VERDICT_BADSUM;
          else if (dest_id != own_id || relay) r.verdict = VERDICT_FORWARD;
          else if (order_b == OrderTakeoff) r.verdict = VERDICT_TAKEOFF;
          else if (order_b == OrderGoto) r.verdict = VERDICT_GOTO;
          else if (order_b == OrderLand) r.verdict = VERDICT_LAND;
          else r.verdict = VERDICT_UNKNOWN;
          parse_phase = WAIT_START;
          pay_cnt     = '0;
        end
      endcase
      r.len   = frame_len;
      r.order = order_b;
      r.w0    = words[0];
      r.w1    = words[1];
      r.w2    = words[2];
      verdict_count[r.verdict]++;
      pending.push_back(r);
    endfunction

    function void compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
        $error("%s: expected %0h, got %0h", name, exp_v, act_v);
        failures++;
      end
    endfunction

    function void check_result(frame_result_t act);
      frame_result_t exp_r;
      results_seen++;
      if (pending.size() == 0) begin
        $error("result transaction with no byte pending, echo %0h", act.echo);
        failures++;
        return;
      end
      exp_r = pending.pop_front();
      compare_field("echo_byte", exp_r.echo, act.echo);
      compare_field("in_frame", exp_r.in_frame, act.in_frame);
      compare_field("frame_end", exp_r.frame_end, act.frame_end);
      compare_field("verdict", exp_r.verdict, act.verdict);
      compare_field("payload_length", exp_r.len, act.len);
      compare_field("order_code", exp_r.order, act.order);
      compare_field("word_first", exp_r.w0, act.w0);
      compare_field("word_second", exp_r.w1, act.w1);
      compare_field("word_third", exp_r.w2, act.w2);
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        own_id_we_i = 1'b0;
  logic [7:0]  own_id_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [7:0]  rx_byte_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [7:0]  echo_byte_o;
  logic        in_frame_o;
  logic        frame_end_o;
  logic [2:0]  verdict_o;
  logic [7:0]  payload_length_o;
  logic [7:0]  order_code_o;
  logic [31:0] word_first_o;
  logic [31:0] word_second_o;
  logic [31:0] word_third_o;

  frame_scoreboard sb = new();
  bit          quiet = 1'b0;
  int          send_idle_pct = 0;
  int          sent = 0;
  int          cycles = 0;

  serial_command_frame_parser dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .own_id_we_i      (own_id_we_i),
    .own_id_i         (own_id_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .rx_byte_i        (rx_byte_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .echo_byte_o      (echo_byte_o),
    .in_frame_o       (in_frame_o),
    .frame_end_o      (frame_end_o),
    .verdict_o        (verdict_o),
    .payload_length_o (payload_length_o),
    .order_code_o     (order_code_o),
    .word_first_o     (word_first_o),
    .word_second_o    (word_second_o),
    .word_third_o     (word_third_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles, %0d transactions still pending",
               cycles, sb.pending.size());
      $display("FAIL");
      $finish;
    end
  end

  always @(posedge clk_i) begin : result_monitor
    frame_result_t act;
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i == 1'b0) begin
      act.echo      = echo_byte_o;
      act.in_frame  = in_frame_o;
      act.frame_end = frame_end_o;
      act.verdict   = verdict_e'(verdict_o);
      act.len       = payload_length_o;
      act.order     = order_code_o;
      act.w0        = word_first_o;
      act.w1        = word_second_o;
      act.w2        = word_third_o;
      sb.check_result(act);
    end
  end

  // output side back-pressure: stall bursts mixed with free-running stretches
  initial begin : stall_driver
    int n;
    bit level;
    @(posedge rst_ni);
    forever begin
      if (quiet) begin
        n = 1;
        level = 1'b0;
      end else if ($urandom_range(0, 99) < 30) begin
        n = $urandom_range(1, 9);
        level = 1'b1;
      end else begin
        n = $urandom_range(1, 40);
        level = 1'b0;
      end
      repeat (n) begin
        @(negedge clk_i);
        out_stall_i = level;
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (!quiet && $urandom_range(0, 99) < send_idle_pct) begin
      gap = $urandom_range(1, 9);
      repeat (gap) begin
        @(negedge clk_i);
        in_valid_i = 1'b0;
      end
    end
    @(negedge clk_i);
    in_valid_i = 1'b1;
    rx_byte_i  = b;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    sb.note_byte(b);
    sent++;
  endtask

  // start, length, marker, id, order, filler, sum; cut > 0 keeps only the first cut bytes
  task automatic send_frame(input logic [7:0] start_b, input logic [7:0] len_b,
                            input logic [7:0] mark_b, input logic [7:0] dest_b,
                            input logic [7:0] order_b, input bit sum_ok, input int cut);
    logic [7:0] frame_bytes [$];
    logic [7:0] frame_sum;
    int n_pay;
    int n_send;
    n_pay = (len_b == 0) ? 1 : int'(len_b);
    frame_bytes.push_back(start_b);
    frame_bytes.push_back(len_b);
    frame_bytes.push_back(mark_b);
    for (int i = 1; i < n_pay; i++) begin
      if (i == 1) frame_bytes.push_back(dest_b);
      else if (i == 2) frame_bytes.push_back(order_b);
      else frame_bytes.push_back(8'($urandom_range(0, 255)));
    end
    frame_sum = '0;
    foreach (frame_bytes[i]) frame_sum = frame_sum + frame_bytes[i];
    if (!sum_ok) frame_sum = frame_sum ^ (8'd1 << $urandom_range(0, 7));
    frame_bytes.push_back(frame_sum);
    n_send = (cut > 0 && cut < frame_bytes.size()) ? cut : frame_bytes.size();
    for (int i = 0; i < n_send; i++) send_byte(frame_bytes[i]);
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic write_own_id(input logic [7:0] v);
    @(negedge clk_i);
    own_id_we_i = 1'b1;
    own_id_i    = v;
    @(negedge clk_i);
    own_id_we_i = 1'b0;
    sb.own_id   = v;
  endtask

  task automatic send_random_frame(input bit sum_ok, input int cut, input bit bad_mark);
    logic [7:0] start_b;
    logic [7:0] mark_b;
    logic [7:0] len_b;
    logic [7:0] dest_b;
    logic [7:0] order_b;
    int r;
    start_b = ($urandom_range(0, 3) == 0) ? StartRelay : StartLocal;
    mark_b  = (start_b == StartRelay) ? MarkRelay : MarkLocal;
    if (bad_mark) begin
      if ($urandom_range(0, 1) == 0) mark_b = (start_b == StartRelay) ? MarkLocal : MarkRelay;
      else mark_b = mark_b ^ 8'($urandom_range(1, 255));
    end
    r = $urandom_range(0, 99);
    if (r < 3) len_b = 8'($urandom_range(20, 255));
    else if (r < 20) len_b = 8'($urandom_range(12, 24));
    else len_b = 8'($urandom_range(0, 16));
    dest_b = ($urandom_range(0, 9) < 7) ? sb.own_id : 8'($urandom_range(0, 255));
    case ($urandom_range(0, 4))
      0: order_b = OrderTakeoff;
      1: order_b = OrderGoto;
      2: order_b = OrderLand;
      3: order_b = 8'($urandom_range(0, 255));
      default: order_b = 8'($urandom_range(3, 255));
    endcase
    send_frame(start_b, len_b, mark_b, dest_b, order_b, sum_ok, cut);
  endtask

  initial begin : stimulus
    logic [7:0] own_id_plan [4];
    int phase_end;
    int r;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: idle noise at both extremes, wrong marker, zero length,
    // a local takeoff, a relay frame and a bad sum
    send_byte(8'h00);
    send_byte(8'hFF);
    send_frame(StartLocal, 8'd5, MarkRelay, OwnIdReset, OrderTakeoff, 1'b1, 3);
    send_frame(StartLocal, 8'd0, MarkLocal, 8'd0, 8'd0, 1'b1, 0);
    send_frame(StartLocal, 8'd3, MarkLocal, OwnIdReset, OrderTakeoff, 1'b1, 0);
    send_frame(StartRelay, 8'd3, MarkRelay, OwnIdReset, OrderLand, 1'b1, 0);
    send_frame(StartLocal, 8'd4, MarkLocal, OwnIdReset, OrderGoto, 1'b0, 0);

    own_id_plan[0] = 8'h00;
    own_id_plan[1] = 8'hFF;
    own_id_plan[2] = 8'($urandom_range(2, 254));
    own_id_plan[3] = OwnIdReset;
    for (int p = 0; p < 4; p++) begin
      wait_idle();
      write_own_id(own_id_plan[p]);
      quiet = (p == 3);
      phase_end = sent + 350;
      while (sent < phase_end) begin
        case ($urandom_range(0, 2))
          0: send_idle_pct = 0;
          1: send_idle_pct = 15;
          default: send_idle_pct = 40;
        endcase
        r = $urandom_range(0, 99);
        if (r < 65) begin
          send_random_frame($urandom_range(0, 9) != 0, 0, 1'b0);
        end else if (r < 75) begin
          repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
        end else if (r < 87) begin
          send_random_frame(1'b1, 3, 1'b1);
        end else begin
          // cut short unless the frame fits in the cut: whatever follows lands inside the stale frame
          send_random_frame(1'b1, $urandom_range(1, 12), 1'b0);
        end
      end
    end

    wait_idle();
    repeat (4) @(posedge clk_i);
    $display("%0d bytes sent, %0d result transactions checked over 4 id settings",
             sent, sb.results_seen);
    $display("verdicts: abort %0d, bad sum %0d, forward %0d, takeoff %0d, goto %0d, land %0d, unknown %0d",
             sb.verdict_count[VERDICT_ABORT], sb.verdict_count[VERDICT_BADSUM],
             sb.verdict_count[VERDICT_FORWARD], sb.verdict_count[VERDICT_TAKEOFF],
             sb.verdict_count[VERDICT_GOTO], sb.verdict_count[VERDICT_LAND],
             sb.verdict_count[VERDICT_UNKNOWN]);
    if (sb.failures == 0 && sb.pending.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
